// File: rtl/bse_pkg.sv
// ----------------------------------------------------------------------------
// bse_pkg
// Types and constants shared by the BMP stream encoder.
// ----------------------------------------------------------------------------
package bse_pkg;

	localparam int CFG_W   = 13;
	localparam int IDX_W   = 6;
	localparam int ROWB_W  = 15;
	localparam int BITMAP_W = 28;

	localparam logic [0:0] REG_IMAGE_WIDTH  = 1'b0;
	localparam logic [0:0] REG_IMAGE_HEIGHT = 1'b1;

	localparam logic [7:0] MAGIC_B = 8'h42;
	localparam logic [7:0] MAGIC_M = 8'h4D;

	localparam logic [IDX_W-1:0] IDX_MAGIC_B = 6'd0;
	localparam logic [IDX_W-1:0] IDX_MAGIC_M = 6'd1;
	localparam logic [IDX_W-1:0] IDX_FIELDS  = 6'd2;
	localparam logic [IDX_W-1:0] IDX_BLUE    = 6'd54;
	localparam logic [IDX_W-1:0] IDX_GREEN   = 6'd55;
	localparam logic [IDX_W-1:0] IDX_RED     = 6'd56;

	localparam logic [31:0] HEADER_BYTES = 32'd54;
	localparam logic [31:0] DIB_SIZE     = 32'd40;
	localparam logic [31:0] PLANES_BPP   = 32'h0018_0001;
	localparam logic [31:0] PELS_PER_M   = 32'd2835;

	localparam logic [3:0] SLOT_FILE_SIZE = 4'd0;
	localparam logic [3:0] SLOT_OFFSET    = 4'd2;
	localparam logic [3:0] SLOT_DIB_SIZE  = 4'd3;
	localparam logic [3:0] SLOT_WIDTH     = 4'd4;
	localparam logic [3:0] SLOT_HEIGHT    = 4'd5;
	localparam logic [3:0] SLOT_PLANES    = 4'd6;
	localparam logic [3:0] SLOT_BITMAP    = 4'd8;
	localparam logic [3:0] SLOT_XRES      = 4'd9;
	localparam logic [3:0] SLOT_YRES      = 4'd10;

	typedef struct packed {
		logic [7:0] red_level;
		logic [7:0] green_level;
		logic [7:0] blue_level;
	} pixel_t;

	typedef struct packed {
		logic [7:0] file_byte;
		logic       run_end;
		logic       image_end;
	} stream_t;

	typedef struct packed {
		pixel_t           pixel;
		logic             header;
		logic [1:0]       pad;
		logic             image_last;
		logic [CFG_W-1:0] width;
		logic [CFG_W-1:0] height;
	} job_t;

endpackage

// File: rtl/bmp_stream_encoder_top.sv
// ----------------------------------------------------------------------------
// bmp_stream_encoder_top
// Streams an uncompressed 24-bit BMP file, one byte per transaction.
// ----------------------------------------------------------------------------
// Each accepted pixel produces its bytes on the stream channel at one byte per
// cycle while stream_stall is low: 3 bytes (blue, green, red), plus (width
// mod 4) zero bytes after the last pixel of a row, plus the 54-byte header
// before the first pixel of an image. A pixel therefore occupies 3 to 60 bytes,
// and the next pixel is taken in the cycle its predecessor's last byte is
// issued, so the byte stream has no gaps while pixels are ready.
// Width and height are clamped to 1..MAX_DIMENSION. The last byte of a pixel
// carries run_end and the last byte of the file also carries image_end.
module bmp_stream_encoder_top import bse_pkg::*; #(
	parameter int MAX_DIMENSION = 4096
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [0:0]       cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	input  logic             pixel_valid,
	output logic             pixel_stall,
	input  pixel_t           pixel_data,
	output logic             stream_valid,
	input  logic             stream_stall,
	output stream_t          stream_data
);

	localparam int CNT_W = (MAX_DIMENSION > 2) ? $clog2(MAX_DIMENSION) : 1;
	localparam int CMP_W = ((CNT_W > CFG_W) ? CNT_W : CFG_W) + 1;

	logic [CFG_W-1:0]    width_q;
	logic [CFG_W-1:0]    height_q;
	logic [CNT_W-1:0]    column_q;
	logic [CNT_W-1:0]    row_q;
	logic                header_done_q;
	logic                valid_s1;
	job_t                job_s1;
	logic [IDX_W-1:0]    idx_q;
	logic [BITMAP_W-1:0] bitmap_q;
	logic [31:0]         total_q;
	logic                out_valid_q;
	stream_t             out_q;

	logic [CFG_W-1:0]    width_eff;
	logic [CFG_W-1:0]    height_eff;
	logic                row_last;
	logic                image_last;
	logic                accept;
	logic                emit;
	logic                last_byte;
	logic [IDX_W-1:0]    last_idx;
	logic [ROWB_W-1:0]   row_bytes;
	logic [IDX_W-1:0]    hdr_off;
	logic [31:0]         hdr_word;
	logic [7:0]          next_byte;

	function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
		logic [CFG_W-1:0] r;
		r = v;
		if (v == '0) begin
			r = CFG_W'(1);
		end else if (32'(v) > 32'(MAX_DIMENSION)) begin
			r = CFG_W'(MAX_DIMENSION);
		end
		return r;
	endfunction

	assign width_eff  = clamp_dim(width_q);
	assign height_eff = clamp_dim(height_q);
	assign row_last   = (CMP_W'(column_q) + CMP_W'(1)) >= CMP_W'(width_eff);
	assign image_last = row_last && ((CMP_W'(row_q) + CMP_W'(1)) >= CMP_W'(height_eff));

	assign last_idx    = IDX_RED + IDX_W'(job_s1.pad);
	assign last_byte   = (idx_q == last_idx);
	assign emit        = valid_s1 && (!out_valid_q || !stream_stall);
	assign pixel_stall = valid_s1 && !(emit && last_byte);
	assign accept      = pixel_valid && !pixel_stall;

	assign row_bytes = ROWB_W'(job_s1.width) + ROWB_W'({job_s1.width, 1'b0})
		+ ROWB_W'(job_s1.width[1:0]);
	assign hdr_off   = idx_q - IDX_FIELDS;

	always_comb begin
		unique case (hdr_off[5:2])
			SLOT_FILE_SIZE: hdr_word = total_q;
			SLOT_OFFSET:    hdr_word = HEADER_BYTES;
			SLOT_DIB_SIZE:  hdr_word = DIB_SIZE;
			SLOT_WIDTH:     hdr_word = 32'(job_s1.width);
			SLOT_HEIGHT:    hdr_word = 32'(job_s1.height);
			SLOT_PLANES:    hdr_word = PLANES_BPP;
			SLOT_BITMAP:    hdr_word = 32'(bitmap_q);
			SLOT_XRES:      hdr_word = PELS_PER_M;
			SLOT_YRES:      hdr_word = PELS_PER_M;
			default:        hdr_word = '0;
		endcase
	end

	always_comb begin
		priority if (idx_q == IDX_MAGIC_B) begin
			next_byte = MAGIC_B;
		end else if (idx_q == IDX_MAGIC_M) begin
			next_byte = MAGIC_M;
		end else if (idx_q < IDX_BLUE) begin
			next_byte = hdr_word[8*hdr_off[1:0] +: 8];
		end else if (idx_q == IDX_BLUE) begin
			next_byte = job_s1.pixel.blue_level;
		end else if (idx_q == IDX_GREEN) begin
			next_byte = job_s1.pixel.green_level;
		end else if (idx_q == IDX_RED) begin
			next_byte = job_s1.pixel.red_level;
		end else begin
			next_byte = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= CFG_W'(1);
			height_q <= CFG_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH:  width_q  <= cfg_data;
				REG_IMAGE_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q      <= '0;
			row_q         <= '0;
			header_done_q <= 1'b0;
		end else if (accept) begin
			if (row_last) begin
				column_q <= '0;
				row_q    <= image_last ? '0 : row_q + CNT_W'(1);
			end else begin
				column_q <= column_q + CNT_W'(1);
			end
			header_done_q <= !image_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			idx_q    <= '0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
			idx_q    <= header_done_q ? IDX_BLUE : IDX_MAGIC_B;
		end else if (emit) begin
			valid_s1 <= !last_byte;
			idx_q    <= idx_q + IDX_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			job_s1.pixel      <= pixel_data;
			job_s1.header     <= !header_done_q;
			job_s1.pad        <= row_last ? width_eff[1:0] : 2'd0;
			job_s1.image_last <= image_last;
			job_s1.width      <= width_eff;
			job_s1.height     <= height_eff;
		end
		bitmap_q <= BITMAP_W'(row_bytes) * BITMAP_W'(job_s1.height);
		total_q  <= 32'(bitmap_q) + HEADER_BYTES;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!stream_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q.file_byte <= next_byte;
			out_q.run_end   <= last_byte;
			out_q.image_end <= last_byte && job_s1.image_last;
		end
	end

	assign stream_valid = out_valid_q;
	assign stream_data  = out_q;

`ifndef SYNTH
	// An image end is always the last byte of its pixel.
	a_image_end_run_end: assert property (@(posedge clk) disable iff (!arst_n)
		stream_valid && stream_data.image_end |-> stream_data.run_end)
		else $error("image_end without run_end");

	// With no pixel in work, the input side never stalls.
	a_idle_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> !pixel_stall)
		else $error("stall with empty pixel stage");

	// The byte index never runs past the pixel's last byte.
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> idx_q <= last_idx)
		else $error("byte index beyond last byte");

	// A pixel that needs a header starts at the first magic byte.
	a_header_start: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !header_done_q |=> idx_q == IDX_MAGIC_B && job_s1.header)
		else $error("header not started at first byte");
`endif

endmodule

// File: tb/bmp_stream_encoder_top_tb.sv
// ----------------------------------------------------------------------------
// bmp_stream_encoder_top_tb
// Checks the BMP byte stream produced for a stream of RGB pixels.
// ----------------------------------------------------------------------------
// A short table of pixels and register writes comes first. Some of its rows
// carry a hand-written byte count and image-end flag for the pixel. After the
// table, random images of mostly small sizes run under three patterns of
// idling, and one long hold on the output fills the block. Every output byte
// is compared with a model of the file format kept inside this bench.
module bmp_stream_encoder_top_tb import bse_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_DIM = 4096;
	localparam int DRAIN_CYCLES = 8;
	localparam int HOLD_CYCLES = 300;
	localparam int PHASE_PIXELS = 112;

	typedef enum logic {STEP_CFG, STEP_PIXEL} step_kind_t;

	typedef struct {
		step_kind_t       kind;
		logic [0:0]       sel;
		logic [CFG_W-1:0] value;
		pixel_t           pixel;
		int               bytes;
		bit               image_end;
	} directed_step_t;

	typedef struct {
		bit known;
		int bytes;
		bit image_end;
	} run_check_t;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [0:0]       cfg_index;
	logic [CFG_W-1:0] cfg_data;
	logic             pixel_valid;
	logic             pixel_stall;
	pixel_t           pixel_data;
	logic             stream_valid;
	logic             stream_stall;
	stream_t          stream_data;

	// File model state.
	logic [CFG_W-1:0] width_reg;
	logic [CFG_W-1:0] height_reg;
	logic [11:0]      col_pos;
	logic [11:0]      row_pos;
	logic             header_sent;

	stream_t    file_bytes [$];
	run_check_t run_checks [$];
	stream_t    want;
	run_check_t chk;

	int  send_gap_pct;
	int  recv_gap_pct;
	logic hold_req;
	int  holds_done;
	int  run_len;
	int  error_count;
	int  pixels_sent;
	int  pixels_accepted;
	int  bytes_checked;
	int  images_seen;

	directed_step_t plan [27] = '{
		'{STEP_PIXEL, REG_IMAGE_WIDTH,  13'd0,    24'hFF0080, 58, 1'b1},
		'{STEP_PIXEL, REG_IMAGE_WIDTH,  13'd0,    24'h00FF7F, 58, 1'b1},
		'{STEP_CFG,   REG_IMAGE_WIDTH,  13'd0,    24'h000000, 0,  1'b0},
		'{STEP_CFG,   REG_IMAGE_HEIGHT, 13'd0,    24'h000000, 0,  1'b0},
		'{STEP_PIXEL, REG_IMAGE_WIDTH,  13'd0,    24'hA55AC3, 58, 1'b1},
		'{STEP_CFG,   REG_IMAGE_WIDTH,  13'd8191, 24'h000000, 0,  1'b0},
		'{STEP_CFG,   REG_IMAGE_HEIGHT, 13'd8191, 24'h000000, 0,  1'b0},
		'{STEP_PIXEL, REG_IMAGE_WIDTH,  13'd0,    24'h010203, 57, 1'b0},
		'{STEP_PIXEL, REG_IMAGE_WIDTH,  13'd0,    24'h804020, 3,  1'b0},
		'{STEP_CFG,   REG_IMAGE_WIDTH,  13'd4096, 24'h000000, 0,  1'b0},
		'{STEP_CFG,   REG_IMAGE_HEIGHT, 13'd4096, 24'h000000, 0,  1'b0},
		'{STEP_PIXEL, REG_IMAGE_WIDTH,  13'd0,    24'hFEFDFB, 3,  1'b0},
		'{STEP_CFG,   REG_IMAGE_WIDTH,  13'd4,    24'h000000, 0,  1'b0},
		'{STEP_CFG,   REG_IMAGE_HEIGHT, 13'd1,    24'h000000, 0,  1'b0},
		'{STEP_PIXEL, REG_IMAGE_WIDTH,  13'd0,    24'h7F8001, 3,  1'b1},
		'{STEP_CFG,   REG_IMAGE_WIDTH,  13'd3,    24'h000000, 0,  1'b0},
		'{STEP_CFG,   REG_IMAGE_HEIGHT, 13'd2,    24'h000000, 0,  1'b0},
		'{STEP_PIXEL, REG_IMAGE_WIDTH,  13'd0,    24'h123456, 57, 1'b0},
		'{STEP_PIXEL, REG_IMAGE_WIDTH,  13'd0,    24'hFFFFFF, 3,  1'b0},
		'{STEP_PIXEL, REG_IMAGE_WIDTH,  13'd0,    24'h000000, 6,  1'b0},
		'{STEP_PIXEL, REG_IMAGE_WIDTH,  13'd0,    24'h55AA55, 3,  1'b0},
		'{STEP_PIXEL, REG_IMAGE_WIDTH,  13'd0,    24'hAA55AA, 3,  1'b0},
		'{STEP_PIXEL, REG_IMAGE_WIDTH,  13'd0,    24'h0F0F0F, 6,  1'b1},
		'{STEP_CFG,   REG_IMAGE_WIDTH,  13'd2,    24'h000000, 0,  1'b0},
		'{STEP_CFG,   REG_IMAGE_HEIGHT, 13'd1,    24'h000000, 0,  1'b0},
		'{STEP_PIXEL, REG_IMAGE_WIDTH,  13'd0,    24'h3C5A96, 0,  1'b0},
		'{STEP_PIXEL, REG_IMAGE_WIDTH,  13'd0,    24'hC3A569, 0,  1'b0}
	};

	bmp_stream_encoder_top #(
		.MAX_DIMENSION(MAX_DIM)
	) u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.pixel_valid (pixel_valid),
		.pixel_stall (pixel_stall),
		.pixel_data  (pixel_data),
		.stream_valid(stream_valid),
		.stream_stall(stream_stall),
		.stream_data (stream_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#(10_000_000);
		$display("FAILURE");
		$finish;
	end

	function automatic int clamp_dim(input logic [CFG_W-1:0] v);
		if (v == 0) return 1;
		if (int'(v) > MAX_DIM) return MAX_DIM;
		return int'(v);
	endfunction

	task automatic push_byte(input logic [7:0] b, input logic last, input logic img_last);
		stream_t s;
		s.file_byte = b;
		s.run_end = last;
		s.image_end = img_last;
		file_bytes.push_back(s);
	endtask

	task automatic push_word(input logic [31:0] v, input int n);
		for (int i = 0; i < n; i++) push_byte(v[8*i +: 8], 1'b0, 1'b0);
	endtask

	task automatic encode_pixel(input pixel_t p);
		int w;
		int h;
		int pad;
		logic row_done;
		logic image_done;
		logic [31:0] bitmap;
		w = clamp_dim(width_reg);
		h = clamp_dim(height_reg);
		pad = w % 4;
		if (!header_sent) begin
			bitmap = 32'((3 * w + pad) * h);
			push_byte(MAGIC_B, 1'b0, 1'b0);
			push_byte(MAGIC_M, 1'b0, 1'b0);
			push_word(bitmap + HEADER_BYTES, 4);
			push_word(32'd0, 4);
			push_word(HEADER_BYTES, 4);
			push_word(DIB_SIZE, 4);
			push_word(32'(w), 4);
			push_word(32'(h), 4);
			push_word(PLANES_BPP, 4);
			push_word(32'd0, 4);
			push_word(bitmap, 4);
			push_word(PELS_PER_M, 4);
			push_word(PELS_PER_M, 4);
			push_word(32'd0, 4);
			push_word(32'd0, 4);
			header_sent = 1'b1;
		end
		row_done = (int'(col_pos) + 1 >= w);
		image_done = row_done && (int'(row_pos) + 1 >= h);
		push_byte(p.blue_level, 1'b0, 1'b0);
		push_byte(p.green_level, 1'b0, 1'b0);
		push_byte(p.red_level, !row_done || pad == 0, image_done && pad == 0);
		if (row_done) begin
			for (int i = 0; i < pad; i++) begin
				push_byte(8'h00, i == pad - 1, image_done && i == pad - 1);
			end
			col_pos = '0;
			if (image_done) begin
				row_pos = '0;
				header_sent = 1'b0;
			end else begin
				row_pos = row_pos + 1'b1;
			end
		end else begin
			col_pos = col_pos + 1'b1;
		end
	endtask

	task automatic flag_error(input string msg);
		error_count++;
		if (error_count <= 10) $display("%t: %s", $realtime, msg);
	endtask

	// Register writes, pixel predictions and byte checks all sample at the edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_reg = 13'd1;
			height_reg = 13'd1;
			col_pos = '0;
			row_pos = '0;
			header_sent = 1'b0;
			run_len = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_IMAGE_WIDTH) begin
					width_reg = cfg_data;
				end else begin
					height_reg = cfg_data;
				end
			end
			if (pixel_valid && !pixel_stall) begin
				pixels_accepted++;
				encode_pixel(pixel_data);
			end
			if (stream_valid && !stream_stall) begin
				bytes_checked++;
				if (stream_data.image_end === 1'b1) images_seen++;
				if (file_bytes.size() == 0) begin
					flag_error($sformatf("unexpected byte %02h run_end %b image_end %b",
						stream_data.file_byte, stream_data.run_end,
						stream_data.image_end));
				end else begin
					want = file_bytes.pop_front();
					run_len++;
					if (stream_data.file_byte !== want.file_byte ||
							stream_data.run_end !== want.run_end ||
							stream_data.image_end !== want.image_end) begin
						flag_error($sformatf({"byte %0d: expected %02h/%b/%b",
							" got %02h/%b/%b"}, bytes_checked,
							want.file_byte, want.run_end, want.image_end,
							stream_data.file_byte, stream_data.run_end,
							stream_data.image_end));
					end
					if (want.run_end) begin
						if (run_checks.size() != 0) begin
							chk = run_checks.pop_front();
							if (chk.known && (run_len != chk.bytes ||
									want.image_end != chk.image_end)) begin
								flag_error($sformatf({"pixel run: expected %0d bytes",
									" image_end %b, model gives %0d bytes image_end %b"},
									chk.bytes, chk.image_end, run_len, want.image_end));
							end
						end
						run_len = 0;
					end
				end
			end
		end
	end

	// Output stall: random idling, or a long hold when one is requested.
	initial begin
		stream_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req <= 1'b0;
				stream_stall <= 1'b1;
				for (int i = 0; i < HOLD_CYCLES; i++) @(posedge clk);
				holds_done++;
			end
			stream_stall <= ($urandom_range(99) < recv_gap_pct);
		end
	end

	task automatic send_pixel(input pixel_t p, input run_check_t c);
		run_checks.push_back(c);
		pixels_sent++;
		cfg_we <= 1'b0;
		while ($urandom_range(99) < send_gap_pct) begin
			pixel_valid <= 1'b0;
			@(posedge clk);
		end
		pixel_valid <= 1'b1;
		pixel_data <= p;
		@(posedge clk);
		while (pixel_stall) @(posedge clk);
	endtask

	task automatic wait_idle();
		pixel_valid <= 1'b0;
		cfg_we <= 1'b0;
		@(posedge clk);
		while (file_bytes.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [0:0] sel, input logic [CFG_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= sel;
		cfg_data <= value;
		@(posedge clk);
	endtask

	task automatic run_image(input logic [CFG_W-1:0] w_raw, input logic [CFG_W-1:0] h_raw,
			input int count);
		logic [23:0] bits;
		wait_idle();
		write_reg(REG_IMAGE_WIDTH, w_raw);
		write_reg(REG_IMAGE_HEIGHT, h_raw);
		for (int k = 0; k < count; k++) begin
			bits = 24'($urandom);
			send_pixel(pixel_t'(bits), '{1'b0, 0, 1'b0});
		end
	endtask

	initial begin
		int phase_start;
		int pick;
		int count;
		logic [CFG_W-1:0] w_raw;
		logic [CFG_W-1:0] h_raw;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_IMAGE_WIDTH;
		cfg_data = '0;
		pixel_valid = 1'b0;
		pixel_data = '0;
		hold_req = 1'b0;
		send_gap_pct = 0;
		recv_gap_pct = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].kind == STEP_CFG) begin
				wait_idle();
				write_reg(plan[i].sel, plan[i].value);
			end else begin
				send_pixel(plan[i].pixel,
					'{plan[i].bytes != 0, plan[i].bytes, plan[i].image_end});
			end
		end

		for (int phase = 0; phase < 3; phase++) begin
			unique case (phase)
				0: begin
					send_gap_pct = 6;
					recv_gap_pct = 70;
				end
				1: begin
					send_gap_pct = 70;
					recv_gap_pct = 6;
				end
				default: begin
					send_gap_pct = 0;
					recv_gap_pct = 0;
					run_image(13'd6, 13'd3, 0);
					hold_req <= 1'b1;
					for (int k = 0; k < 18; k++) begin
						send_pixel(pixel_t'(24'($urandom)), '{1'b0, 0, 1'b0});
					end
				end
			endcase
			phase_start = pixels_sent;
			while (pixels_sent - phase_start < PHASE_PIXELS) begin
				pick = $urandom_range(99);
				if (pick < 6) begin
					w_raw = ($urandom_range(1) == 1) ? 13'(MAX_DIM) :
						13'($urandom_range(8191, MAX_DIM + 1));
					h_raw = 13'($urandom);
					count = $urandom_range(4, 1);
				end else begin
					w_raw = 13'($urandom_range(9, 0));
					h_raw = 13'($urandom_range(4, 0));
					count = clamp_dim(w_raw) * clamp_dim(h_raw);
					// Some images are cut short and the next one starts mid-row.
					if (pick < 16) count = $urandom_range(count, 1);
				end
				run_image(w_raw, h_raw, count);
			end
		end

		wait_idle();
		$display("Sent %0d pixels, checked %0d bytes across %0d complete images.",
			pixels_accepted, bytes_checked, images_seen);
		$display("Output holds of %0d cycles: %0d; mismatches: %0d.",
			HOLD_CYCLES, holds_done, error_count);
		if (error_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

// File: filelist.f
rtl/bse_pkg.sv
rtl/bmp_stream_encoder_top.sv
tb/bmp_stream_encoder_top_tb.sv
